@@ sv/oli_pkg.sv @@
// Shared types, request codes and status codes for the ordered list block.
package oli_pkg;

   localparam int OLI_DEPTH       = 64;
   localparam int OLI_HANDLE_BITS = 32;

   localparam int FUNC_W   = 3;
   localparam int STATUS_W = 2;

   localparam logic [FUNC_W-1:0] F_APPEND = 3'd0;
   localparam logic [FUNC_W-1:0] F_INSERT = 3'd1;
   localparam logic [FUNC_W-1:0] F_REMOVE = 3'd2;
   localparam logic [FUNC_W-1:0] F_DELETE = 3'd3;
   localparam logic [FUNC_W-1:0] F_GET    = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

   // Shift command broadcast to every cell.
   typedef struct packed {
      logic ins;
      logic rem;
   } cell_cmd_type;

   // Per-cell compare results.
   typedef struct packed {
      logic match;
      logic at_pos;
      logic ge_pos;
   } cell_flags_type;

endpackage

@@ sv/oli_cell.sv @@
// One list slot: holds an entry, compares it, and shifts from a neighbor.
module oli_cell #(
   parameter int IDX         = 0,
   parameter int HANDLE_BITS = oli_pkg::OLI_HANDLE_BITS,
   parameter int CNT_W       = 7
) (
   input  logic                      clock,
   input  oli_pkg::cell_cmd_type     cmd,
   input  logic                      sel,
   input  logic                      ge,
   input  logic [CNT_W-1:0]          pos,
   input  logic [CNT_W-1:0]          fill,
   input  logic [HANDLE_BITS-1:0]    handle,
   input  logic [HANDLE_BITS-1:0]    left,
   input  logic [HANDLE_BITS-1:0]    right,
   output logic [HANDLE_BITS-1:0]    entry,
   output oli_pkg::cell_flags_type   flags
);
   import oli_pkg::*;

   localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

   logic [HANDLE_BITS-1:0] entry_ff;
   logic [HANDLE_BITS-1:0] entry_in;

   // Target slot loads on insert; slots above take from the lower neighbor,
   // and on removal the target and everything above take from the upper one.
   always_comb begin
      entry_in = entry_ff;
      if (cmd.ins && sel) begin
         entry_in = handle;
      end else if (cmd.ins && ge) begin
         entry_in = left;
      end else if (cmd.rem && ge) begin
         entry_in = right;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry        = entry_ff;
   assign flags.match  = (entry_ff == handle) && (MY_IDX < fill);
   assign flags.at_pos = (MY_IDX == pos);
   assign flags.ge_pos = (MY_IDX >= pos);

endmodule

@@ sv/ordered_list_insert_remove.sv @@
// Top level of the ordered handle list: request sequencer and chain of slot cells.
//
// Each request passes through the states idle (accept), match (every cell
// compares its entry against the handle and the position), pick (a delete
// selects the first matching cell) and exec (all cells shift at once) before
// the next request is accepted; busy is high in match, pick and exec.
// The result appears on the rsp_ ports with rsp_strobe
// high for exactly one cycle, the cycle after the shift, and is not held:
// the receiver must take it then. Only start and busy gate new requests.
module ordered_list_insert_remove #(
   parameter int DEPTH       = oli_pkg::OLI_DEPTH,
   parameter int HANDLE_BITS = oli_pkg::OLI_HANDLE_BITS,
   parameter int CNT_W       = $clog2(DEPTH + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [oli_pkg::FUNC_W-1:0]    req_func,
   input  logic [CNT_W-1:0]              req_position,
   input  logic [HANDLE_BITS-1:0]        req_handle_in,
   output logic                          rsp_strobe,
   output logic [HANDLE_BITS-1:0]        rsp_handle_out,
   output logic [CNT_W-1:0]              rsp_entry_count,
   output logic [oli_pkg::STATUS_W-1:0]  rsp_status
);
   import oli_pkg::*;

   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_MATCH = 4'b0010,
      S_PICK  = 4'b0100,
      S_EXEC  = 4'b1000
   } state_type;

   state_type                state_ff, state_in;
   logic [FUNC_W-1:0]        func_ff;
   logic [CNT_W-1:0]         pos_ff;
   logic [HANDLE_BITS-1:0]   handle_ff;
   logic [CNT_W-1:0]         fill_ff, fill_in;
   logic [DEPTH-1:0]         match_ff;
   logic [DEPTH-1:0]         sel_ff;
   logic [DEPTH-1:0]         ge_ff;
   logic [DEPTH-1:0]         first_hit;

   logic                     rsp_strobe_ff;
   logic [HANDLE_BITS-1:0]   rsp_handle_ff;
   logic [CNT_W-1:0]         rsp_count_ff;
   logic [STATUS_W-1:0]      rsp_status_ff;

   logic [HANDLE_BITS-1:0]   entry_w [DEPTH];
   logic [HANDLE_BITS-1:0]   left_w  [DEPTH];
   logic [HANDLE_BITS-1:0]   right_w [DEPTH];
   cell_flags_type           flags_w [DEPTH];
   logic [DEPTH-1:0]         match_w, at_w, ge_w;

   cell_cmd_type             cmd;
   logic [HANDLE_BITS-1:0]   read_data;
   logic [HANDLE_BITS-1:0]   hout;
   logic [STATUS_W-1:0]      status;
   logic                     full;
   logic                     accept;

   assign accept = start && (state_ff == S_IDLE);
   assign busy   = (state_ff != S_IDLE);
   assign full   = (fill_ff == FULL_COUNT);

   // Chain of slot cells
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      if (g == 0) begin : g_lo
         assign left_w[g] = '0;
      end else begin : g_lo_n
         assign left_w[g] = entry_w[g-1];
      end
      if (g == DEPTH - 1) begin : g_hi
         assign right_w[g] = '0;
      end else begin : g_hi_n
         assign right_w[g] = entry_w[g+1];
      end

      oli_cell #(
         .IDX         (g),
         .HANDLE_BITS (HANDLE_BITS),
         .CNT_W       (CNT_W)
      ) u_cell (
         .clock  (clock),
         .cmd    (cmd),
         .sel    (sel_ff[g]),
         .ge     (ge_ff[g]),
         .pos    (pos_ff),
         .fill   (fill_ff),
         .handle (handle_ff),
         .left   (left_w[g]),
         .right  (right_w[g]),
         .entry  (entry_w[g]),
         .flags  (flags_w[g])
      );

      assign match_w[g] = flags_w[g].match;
      assign at_w[g]    = flags_w[g].at_pos;
      assign ge_w[g]    = flags_w[g].ge_pos;
   end

   // Isolate the lowest matching cell
   assign first_hit = match_ff & (~match_ff + DEPTH'(1));

   always_comb begin
      read_data = '0;
      for (int i = 0; i < DEPTH; i++) begin
         read_data = read_data | (entry_w[i] & {HANDLE_BITS{sel_ff[i]}});
      end
   end

   // Decide the outcome of the request in the shift cycle
   always_comb begin
      cmd     = '0;
      hout    = '0;
      status  = ST_OK;
      fill_in = fill_ff;
      unique case (func_ff)
         F_APPEND: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               cmd.ins = 1'b1;
               fill_in = fill_ff + CNT_W'(1);
            end
         end
         F_INSERT: begin
            if (full) begin
               status = ST_FULL;
            end else if (pos_ff > fill_ff) begin
               status = ST_RANGE;
            end else begin
               cmd.ins = 1'b1;
               fill_in = fill_ff + CNT_W'(1);
            end
         end
         F_REMOVE: begin
            if (pos_ff >= fill_ff) begin
               status = ST_RANGE;
            end else begin
               cmd.rem = 1'b1;
               hout    = read_data;
               fill_in = fill_ff - CNT_W'(1);
            end
         end
         F_DELETE: begin
            if (|match_ff) begin
               cmd.rem = 1'b1;
               hout    = read_data;
               fill_in = fill_ff - CNT_W'(1);
            end else begin
               status = ST_NOTFOUND;
            end
         end
         F_GET: begin
            if (pos_ff >= fill_ff) begin
               status = ST_RANGE;
            end else begin
               hout = read_data;
            end
         end
         default: begin
         end
      endcase
      if (state_ff != S_EXEC) begin
         cmd     = '0;
         fill_in = fill_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (start) state_in = S_MATCH;
         S_MATCH: state_in = S_PICK;
         S_PICK:  state_in = S_EXEC;
         S_EXEC:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         fill_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         rsp_strobe_ff <= (state_ff == S_EXEC);
      end
   end

   // Request and per-cell decision registers
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff   <= req_func;
         pos_ff    <= (req_func == F_APPEND) ? fill_ff : req_position;
         handle_ff <= req_handle_in;
      end
      if (state_ff == S_MATCH) begin
         match_ff <= match_w;
         sel_ff   <= at_w;
         ge_ff    <= ge_w;
      end
      if (state_ff == S_PICK && func_ff == F_DELETE) begin
         sel_ff <= first_hit;
         ge_ff  <= ~(first_hit - DEPTH'(1));
      end
      if (state_ff == S_EXEC) begin
         rsp_handle_ff <= hout;
         rsp_count_ff  <= fill_in;
         rsp_status_ff <= status;
      end
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_handle_out  = rsp_handle_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_status      = rsp_status_ff;

   a_exec_strobe: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC) |=> rsp_strobe)
      else $error("result strobe missing after shift cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_strobe))
      else $error("accepted request did not raise busy");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == ST_FULL) |-> (rsp_entry_count == FULL_COUNT))
      else $error("full status with list not full");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FULL_COUNT)
      else $error("entry count above capacity");

endmodule
